### hw/rtl/lsb_stego_deframer_unit_defines.svh
// Assertion macros used by the deframer parser RTL.
`ifndef LSB_STEGO_DEFRAMER_UNIT_DEFINES_SVH
`define LSB_STEGO_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTH

`define LSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsd assertion failed");

`define LSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsd assertion failed");

`else

`define LSD_ASSERT_IMP(lbl, ante, cons)

`define LSD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/lsd_pkg.sv
// Types and constants for the LSB stego deframer.
`timescale 1ns / 1ps
package lsd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MAGIC   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_EXTBYTE = 3'd3,
    PH_PAYLEN  = 3'd4,
    PH_PAYBYTE = 3'd5,
    PH_DONE    = 3'd6,
    PH_HALT    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    K_EXT      = 3'd0,
    K_PAY      = 3'd1,
    K_EXTLEN   = 3'd2,
    K_PAYLEN   = 3'd3,
    K_MISMATCH = 3'd4
  } kind_t;

  localparam logic [1:0] CFG_HEADER_SKIP = 2'd0;
  localparam logic [1:0] CFG_MAGIC_CNT   = 2'd1;
  localparam logic [1:0] CFG_MAGIC_WORD  = 2'd2;

  localparam logic [7:0]  HEADER_SKIP_RST = 8'd54;
  localparam logic [3:0]  MAGIC_CNT_RST   = 4'd2;
  localparam logic [63:0] MAGIC_WORD_RST  = 64'h0000_0000_0000_2A23;
  localparam logic [3:0]  MAGIC_CNT_MAX   = 4'd8;
  localparam logic [5:0]  LEN_BITS        = 6'd32;
  localparam logic [5:0]  BYTE_BITS       = 6'd8;

  typedef struct packed {
    logic [7:0]  header_skip;
    logic [3:0]  magic_cnt;
    logic [63:0] magic_word;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } res_t;

endpackage

### hw/rtl/lsd_cfg_regs.sv
// Configuration register file for the deframer.
`timescale 1ns / 1ps
module lsd_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output lsd_pkg::cfg_t      cfg
);

  lsd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_skip <= lsd_pkg::HEADER_SKIP_RST;
      cfg_r.magic_cnt   <= lsd_pkg::MAGIC_CNT_RST;
      cfg_r.magic_word  <= lsd_pkg::MAGIC_WORD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lsd_pkg::CFG_HEADER_SKIP: cfg_r.header_skip <= cfg_data[7:0];
        lsd_pkg::CFG_MAGIC_CNT:   cfg_r.magic_cnt   <= cfg_data[3:0];
        lsd_pkg::CFG_MAGIC_WORD:  cfg_r.magic_word  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/lsd_parser.sv
// Input register, frame parse state and single-pass step logic.
`timescale 1ns / 1ps
`include "lsb_stego_deframer_unit_defines.svh"
module lsd_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  lsd_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_bit,
  input  logic           in_fs,
  output logic           res_valid,
  input  logic           res_ready,
  output lsd_pkg::res_t  res
);

  logic in_v_r, in_bit_r, in_fs_r;

  lsd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [31:0] acc_r, acc_nxt, acc_full;
  logic [4:0]  bc_r, bc_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [2:0]  midx_r, midx_nxt;
  logic        mok_r, mok_nxt;

  logic [3:0]  mlen;
  logic [7:0]  expect_byte;
  logic        go, need_long, more, emit;
  logic [5:0]  bc_inc;
  logic        step;

  assign step     = in_v_r && res_ready;
  assign in_ready = !in_v_r || res_ready;

  assign mlen = (cfg.magic_cnt > lsd_pkg::MAGIC_CNT_MAX) ? lsd_pkg::MAGIC_CNT_MAX
                                                         : cfg.magic_cnt;

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    acc_nxt   = acc_r;
    bc_nxt    = bc_r;
    rem_nxt   = rem_r;
    midx_nxt  = midx_r;
    mok_nxt   = mok_r;
    if (in_fs_r) begin
      phase_nxt = lsd_pkg::PH_HEADER;
      skip_nxt  = '0;
      acc_nxt   = '0;
      bc_nxt    = '0;
      rem_nxt   = '0;
      midx_nxt  = '0;
      mok_nxt   = 1'b1;
    end

    emit       = 1'b0;
    res.kind   = lsd_pkg::K_EXT;
    res.value  = '0;
    res.last   = 1'b0;
    go         = 1'b1;

    if (phase_nxt == lsd_pkg::PH_HEADER) begin
      if (skip_nxt < cfg.header_skip) begin
        skip_nxt = skip_nxt + 8'd1;
        go       = 1'b0;
      end else begin
        phase_nxt = (mlen == 4'd0) ? lsd_pkg::PH_EXTLEN : lsd_pkg::PH_MAGIC;
      end
    end
    if (phase_nxt == lsd_pkg::PH_DONE || phase_nxt == lsd_pkg::PH_HALT) go = 1'b0;

    need_long   = (phase_nxt == lsd_pkg::PH_EXTLEN) || (phase_nxt == lsd_pkg::PH_PAYLEN);
    acc_full    = acc_nxt | (32'(in_bit_r) << bc_nxt);
    bc_inc      = {1'b0, bc_nxt} + 6'd1;
    more        = bc_inc < (need_long ? lsd_pkg::LEN_BITS : lsd_pkg::BYTE_BITS);
    expect_byte = cfg.magic_word[{midx_nxt, 3'b000} +: 8];

    if (go) begin
      if (more) begin
        acc_nxt = acc_full;
        bc_nxt  = bc_inc[4:0];
      end else begin
        acc_nxt = '0;
        bc_nxt  = '0;
        case (phase_nxt)
          lsd_pkg::PH_MAGIC: begin
            if (acc_full != {24'd0, expect_byte}) mok_nxt = 1'b0;
            if ({1'b0, midx_nxt} + 4'd1 < mlen) begin
              midx_nxt = midx_nxt + 3'd1;
            end else begin
              midx_nxt = '0;
              if (!mok_nxt) begin
                phase_nxt = lsd_pkg::PH_HALT;
                emit      = 1'b1;
                res.kind  = lsd_pkg::K_MISMATCH;
              end else begin
                phase_nxt = lsd_pkg::PH_EXTLEN;
              end
            end
          end
          lsd_pkg::PH_EXTLEN: begin
            rem_nxt   = acc_full;
            phase_nxt = (acc_full == '0) ? lsd_pkg::PH_PAYLEN : lsd_pkg::PH_EXTBYTE;
            emit      = 1'b1;
            res.kind  = lsd_pkg::K_EXTLEN;
            res.value = acc_full;
          end
          lsd_pkg::PH_EXTBYTE: begin
            rem_nxt   = rem_nxt - 32'd1;
            if (rem_nxt == '0) phase_nxt = lsd_pkg::PH_PAYLEN;
            emit      = 1'b1;
            res.kind  = lsd_pkg::K_EXT;
            res.value = acc_full;
          end
          lsd_pkg::PH_PAYLEN: begin
            rem_nxt   = acc_full;
            phase_nxt = (acc_full == '0) ? lsd_pkg::PH_DONE : lsd_pkg::PH_PAYBYTE;
            emit      = 1'b1;
            res.kind  = lsd_pkg::K_PAYLEN;
            res.value = acc_full;
            res.last  = (acc_full == '0);
          end
          lsd_pkg::PH_PAYBYTE: begin
            rem_nxt   = rem_nxt - 32'd1;
            emit      = 1'b1;
            res.kind  = lsd_pkg::K_PAY;
            res.value = acc_full;
            if (rem_nxt == '0) begin
              phase_nxt = lsd_pkg::PH_DONE;
              res.last  = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign res_valid = in_v_r && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_bit_r <= in_bit;
      in_fs_r  <= in_fs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lsd_pkg::PH_HEADER;
      skip_r  <= '0;
      acc_r   <= '0;
      bc_r    <= '0;
      rem_r   <= '0;
      midx_r  <= '0;
      mok_r   <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      acc_r   <= acc_nxt;
      bc_r    <= bc_nxt;
      rem_r   <= rem_nxt;
      midx_r  <= midx_nxt;
      mok_r   <= mok_nxt;
    end
  end

  `LSD_ASSERT_IMP(a_paylen_last, res_valid && res.kind == lsd_pkg::K_PAYLEN, res.last == (res.value == '0))
  `LSD_ASSERT_NXT(a_mismatch_halts, step && res_valid && res.kind == lsd_pkg::K_MISMATCH, phase_r == lsd_pkg::PH_HALT)
  `LSD_ASSERT_IMP(a_byte_bitcount, !(phase_r == lsd_pkg::PH_EXTLEN || phase_r == lsd_pkg::PH_PAYLEN), bc_r < 5'd8)
  `LSD_ASSERT_IMP(a_magic_idx_idle, phase_r != lsd_pkg::PH_MAGIC, midx_r == 3'd0)

endmodule

### hw/rtl/lsd_out_stage.sv
// Result register on the output stream.
`timescale 1ns / 1ps
module lsd_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  output logic           res_ready,
  input  lsd_pkg::res_t  res,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [31:0]    out_tdata,
  output logic [2:0]     out_tuser,
  output logic           out_tlast
);

  logic          out_v_r;
  lsd_pkg::res_t out_r;

  assign res_ready  = !out_v_r || out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.value;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_ready) begin
      out_v_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

endmodule

### hw/rtl/lsb_stego_deframer_unit.sv
// Top level of the LSB stego deframer.
//
//  channel | direction | carries
//  in_     | slave     | tdata: pixel_byte[7:0]; tuser: frame_start[0]
//  out_    | master    | tdata: value[31:0]; tuser: kind[2:0]; tlast: last
//  cfg_    | slave     | index 0 header_skip, 1 magic_cnt, 2 magic_word
//
// One image byte per cycle while the output is not stalled: input register, one
// pass of parse logic, result register; at most one result per byte.
// Reset is synchronous: parse state returns to header skip, registers to defaults.
// A stalled output holds its result; input keeps flowing while the output
// register is free or being drained in the same cycle.
`timescale 1ns / 1ps
module lsb_stego_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // pixel_byte[7:0]
  input  logic [0:0]  in_tuser,   // frame_start[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value[31:0]
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  lsd_pkg::cfg_t cfg;
  lsd_pkg::res_t res;
  logic          res_valid, res_ready;

  lsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_bit    (in_tdata[0]),
    .in_fs     (in_tuser[0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  lsd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### tb/lsd_checker.sv
`timescale 1ns / 1ps
// Checker for the deframer: mirrors the parse of each pixel request and compares results.
module lsd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  logic [7:0]  hdr_skip;
  logic [3:0]  mag_len;
  logic [63:0] mag_word;

  lsd_pkg::phase_t ph;
  logic [7:0]  skip_cnt;
  logic [31:0] acc;
  logic [4:0]  bit_cnt;
  logic [31:0] remaining;
  logic [2:0]  mag_idx;
  logic        mag_ok;

  lsd_pkg::res_t decoded_q[$];
  lsd_pkg::res_t oldest;
  int   errs = 0;

  task automatic restart_parse();
    ph        = lsd_pkg::PH_HEADER;
    skip_cnt  = '0;
    acc       = '0;
    bit_cnt   = '0;
    remaining = '0;
    mag_idx   = '0;
    mag_ok    = 1'b1;
  endtask

  task automatic queue_result(input lsd_pkg::kind_t k, input logic [31:0] v,
                              input logic l);
    lsd_pkg::res_t r;
    r.kind  = k;
    r.value = v;
    r.last  = l;
    decoded_q.push_back(r);
  endtask

  task automatic decode_pixel(input logic [7:0] pix, input logic fs);
    logic [3:0]  mlen;
    int          need;
    logic [31:0] word;
    bit          held;
    if (fs) restart_parse();
    mlen = (mag_len > lsd_pkg::MAGIC_CNT_MAX) ? lsd_pkg::MAGIC_CNT_MAX : mag_len;
    held = 1'b0;
    if (ph == lsd_pkg::PH_HEADER) begin
      if (skip_cnt < hdr_skip) begin
        skip_cnt = skip_cnt + 8'd1;
        held = 1'b1;
      end else if (mlen == 4'd0) begin
        ph = lsd_pkg::PH_EXTLEN;
      end else begin
        ph = lsd_pkg::PH_MAGIC;
      end
    end
    if (!held && ph != lsd_pkg::PH_DONE && ph != lsd_pkg::PH_HALT) begin
      need = (ph == lsd_pkg::PH_EXTLEN || ph == lsd_pkg::PH_PAYLEN)
             ? int'(lsd_pkg::LEN_BITS) : int'(lsd_pkg::BYTE_BITS);
      acc[bit_cnt] = pix[0];
      if (int'(bit_cnt) + 1 < need) begin
        bit_cnt = bit_cnt + 5'd1;
      end else begin
        word    = acc;
        acc     = '0;
        bit_cnt = '0;
        case (ph)
          lsd_pkg::PH_MAGIC: begin
            if (word != {24'd0, mag_word[8*mag_idx +: 8]}) mag_ok = 1'b0;
            if (int'(mag_idx) + 1 < int'(mlen)) begin
              mag_idx = mag_idx + 3'd1;
            end else begin
              mag_idx = '0;
              if (!mag_ok) begin
                ph = lsd_pkg::PH_HALT;
                queue_result(lsd_pkg::K_MISMATCH, '0, 1'b0);
              end else begin
                ph = lsd_pkg::PH_EXTLEN;
              end
            end
          end
          lsd_pkg::PH_EXTLEN: begin
            remaining = word;
            if (word == '0) ph = lsd_pkg::PH_PAYLEN;
            else ph = lsd_pkg::PH_EXTBYTE;
            queue_result(lsd_pkg::K_EXTLEN, word, 1'b0);
          end
          lsd_pkg::PH_EXTBYTE: begin
            remaining = remaining - 32'd1;
            if (remaining == '0) ph = lsd_pkg::PH_PAYLEN;
            queue_result(lsd_pkg::K_EXT, word, 1'b0);
          end
          lsd_pkg::PH_PAYLEN: begin
            remaining = word;
            if (word == '0) begin
              ph = lsd_pkg::PH_DONE;
              queue_result(lsd_pkg::K_PAYLEN, word, 1'b1);
            end else begin
              ph = lsd_pkg::PH_PAYBYTE;
              queue_result(lsd_pkg::K_PAYLEN, word, 1'b0);
            end
          end
          lsd_pkg::PH_PAYBYTE: begin
            remaining = remaining - 32'd1;
            if (remaining == '0) begin
              ph = lsd_pkg::PH_DONE;
              queue_result(lsd_pkg::K_PAY, word, 1'b1);
            end else begin
              queue_result(lsd_pkg::K_PAY, word, 1'b0);
            end
          end
          default: ;
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_skip = lsd_pkg::HEADER_SKIP_RST;
      mag_len  = lsd_pkg::MAGIC_CNT_RST;
      mag_word = lsd_pkg::MAGIC_WORD_RST;
      restart_parse();
      decoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lsd_pkg::CFG_HEADER_SKIP: hdr_skip = cfg_data[7:0];
          lsd_pkg::CFG_MAGIC_CNT:   mag_len  = cfg_data[3:0];
          lsd_pkg::CFG_MAGIC_WORD:  mag_word = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) decode_pixel(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: kind %0d, value %h, last %0b",
                 out_tuser, out_tdata, out_tlast);
          errs++;
        end else begin
          oldest = decoded_q.pop_front();
          if (out_tuser !== oldest.kind) begin
            $error("kind: expected %0d, got %0d", oldest.kind, out_tuser);
            errs++;
          end
          if (out_tdata !== oldest.value) begin
            $error("value: expected %h, got %h", oldest.value, out_tdata);
            errs++;
          end
          if (out_tlast !== oldest.last) begin
            $error("last: expected %0b, got %0b", oldest.last, out_tlast);
            errs++;
          end
        end
      end
    end
    mismatches  <= errs;
    outstanding <= decoded_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives framed pixel streams and register writes into the deframer.
module tb_top;

  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [63:0] cfg_data   = '0;

  int mismatches;
  int outstanding;
  int cycles       = 0;
  int bytes_sent   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit fs_next      = 1'b0;

  logic [7:0]  cur_hdr   = lsd_pkg::HEADER_SKIP_RST;
  logic [3:0]  cur_mlen  = lsd_pkg::MAGIC_CNT_RST;
  logic [63:0] cur_magic = lsd_pkg::MAGIC_WORD_RST;

  lsb_stego_deframer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lsd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rx_stall_pct == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL lsb_stego_deframer_unit");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= fs_next;
    fs_next = 1'b0;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hide n bits of v in pixel LSBs, bit 0 first; upper pixel bits are noise.
  task automatic send_bits(input logic [31:0] v, input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b    = 8'($urandom);
      b[0] = v[i];
      send_byte(b);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [2:0] sel, input logic [7:0] h,
                            input logic [3:0] m, input logic [63:0] w);
    logic [1:0] idx;
    settle();
    for (int i = 0; i < 3; i++) begin
      if (sel[i]) begin
        idx = 2'(i);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        case (idx)
          lsd_pkg::CFG_HEADER_SKIP: begin
            cfg_data <= {56'd0, h};
            cur_hdr = h;
          end
          lsd_pkg::CFG_MAGIC_CNT: begin
            cfg_data <= {60'd0, m};
            cur_mlen = m;
          end
          default: begin
            cfg_data <= w;
            cur_magic = w;
          end
        endcase
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // bad_pos < 0 sends the magic intact, otherwise flips one bit of that magic byte.
  task automatic send_frame(input int hdr, input int bad_pos,
                            input logic [31:0] ext_len, input int ext_sent,
                            input logic [31:0] pay_len, input int pay_sent);
    int         mlen;
    logic [7:0] mb;
    mlen = (cur_mlen > lsd_pkg::MAGIC_CNT_MAX) ? int'(lsd_pkg::MAGIC_CNT_MAX)
                                               : int'(cur_mlen);
    fs_next = 1'b1;
    repeat (hdr) send_byte(8'($urandom));
    for (int i = 0; i < mlen; i++) begin
      mb = cur_magic[8*i +: 8];
      if (i == bad_pos) mb = mb ^ (8'd1 << $urandom_range(0, 7));
      send_bits({24'd0, mb}, 8);
    end
    if (bad_pos < 0 || mlen == 0) begin
      send_bits(ext_len, 32);
      repeat (ext_sent) send_bits($urandom, 8);
      send_bits(pay_len, 32);
      repeat (pay_sent) send_bits($urandom, 8);
    end
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
  endtask

  task automatic shuffle_regs();
    logic [7:0]  h;
    logic [3:0]  m;
    logic [63:0] w;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 6) h = 8'($urandom_range(0, 4));
    else if (r == 6) h = 8'd0;
    else if (r == 7) h = 8'd255;
    else h = 8'($urandom);
    r = $urandom_range(0, 9);
    if (r < 6) m = 4'($urandom_range(1, 3));
    else if (r == 6) m = 4'd0;
    else if (r == 7) m = 4'd8;
    else if (r == 8) m = 4'd15;
    else m = 4'($urandom_range(4, 15));
    r = $urandom_range(0, 9);
    if (r == 0) w = '0;
    else if (r == 1) w = '1;
    else w = {$urandom, $urandom};
    write_regs(3'($urandom_range(1, 7)), h, m, w);
  endtask

  task automatic random_frame();
    int          r;
    int          hdr;
    int          bad;
    int          mlen;
    logic [31:0] ext_len;
    logic [31:0] pay_len;
    int          ext_sent;
    int          pay_sent;
    r        = $urandom_range(0, 99);
    mlen     = (cur_mlen > lsd_pkg::MAGIC_CNT_MAX) ? int'(lsd_pkg::MAGIC_CNT_MAX)
                                                   : int'(cur_mlen);
    hdr      = int'(cur_hdr);
    bad      = -1;
    ext_len  = 32'($urandom_range(0, 3));
    pay_len  = 32'($urandom_range(0, 4));
    ext_sent = int'(ext_len);
    pay_sent = int'(pay_len);
    if (r >= 95) begin
      // junk with sporadic restarts
      repeat ($urandom_range(5, 30)) begin
        fs_next = ($urandom_range(0, 9) == 0);
        send_byte(8'($urandom));
      end
    end else begin
      if (r < 8) hdr = $urandom_range(0, int'(cur_hdr) + 2);
      else if (r < 18 && mlen > 0) bad = $urandom_range(0, mlen - 1);
      else if (r < 26) begin
        ext_len  = $urandom;
        ext_sent = $urandom_range(0, 2);
      end else if (r < 32) begin
        pay_len  = $urandom;
        pay_sent = $urandom_range(0, 3);
      end
      send_frame(hdr, bad, ext_len, ext_sent, pay_len, pay_sent);
    end
  endtask

  int tx_pct[4] = '{0, 51, 0, 11};
  int rx_pct[4] = '{0, 0, 51, 11};

  initial begin
    int start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: 54-byte header, two magic bytes
    send_frame(int'(lsd_pkg::HEADER_SKIP_RST), -1, 32'd1, 1, 32'd2, 2);
    // no header, magic skipped, empty extension and payload
    write_regs(3'b011, 8'd0, 4'd0, '0);
    send_frame(0, -1, 32'd0, 0, 32'd0, 0);
    // magic length above eight clamps to eight
    write_regs(3'b110, 8'd0, 4'd15, '1);
    send_frame(0, -1, 32'd2, 2, 32'd1, 1);
    // early mismatch only reported after all magic bytes; halt until restart
    write_regs(3'b111, 8'd255, 4'd3, 64'h0);
    send_frame(255, 0, 32'd0, 0, 32'd0, 0);
    send_frame(255, -1, 32'hFFFF_FFFF, 1, 32'd0, 0);
    // mismatch on the final magic byte
    write_regs(3'b001, 8'd1, 4'd3, '0);
    send_frame(1, 2, 32'd0, 0, 32'd0, 0);
    write_regs(3'b110, 8'd0, 4'd1, {$urandom, $urandom});
    send_frame(0, -1, 32'd0, 0, 32'hFFFF_FFFF, 2);

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      start = bytes_sent;
      while (bytes_sent - start < 75) begin
        if ($urandom_range(0, 4) == 0) shuffle_regs();
        random_frame();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS lsb_stego_deframer_unit");
    end else begin
      $display("FAIL lsb_stego_deframer_unit");
    end
    $finish;
  end

endmodule
